// ===== hw/rtl/sorted_byte_list_defines.svh =====
// Assertion macros used by the list RTL.
`ifndef SORTED_BYTE_LIST_DEFINES_SVH
`define SORTED_BYTE_LIST_DEFINES_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define SBL_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sorted_byte_list assertion failed");
// Checked on every edge, reset included.
`define SBL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sorted_byte_list assertion failed");
`else
`define SBL_ASSERT(label, clk, rst, prop)
`define SBL_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hw/rtl/sbl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbl_pkg;

  localparam int CAPACITY    = 16;
  localparam int DATA_W      = 8;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int COUNT_OUT_W = 5;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Broadcast to every cell: compare phase, then one of the two shifts.
  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sbl_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sbl_req_if;
  import sbl_pkg::*;

  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sbl_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sbl_rsp_if;
  import sbl_pkg::*;

  logic                   valid;
  logic                   ready;
  status_t                status;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic                   list_empty;

  modport source (output valid, output status, output entry_count, output list_empty,
                  input ready);
  modport sink (input valid, input status, input entry_count, input list_empty,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sorted_byte_list.sv =====
// Sorted byte list: keeps up to CAPACITY unsigned bytes in ascending order
// in a row of cells. A request either inserts a byte ahead of the first
// entry not smaller than it (refused with status full when the list is
// full) or deletes the lowest-placed equal entry (status not found when
// absent). Every request gives exactly one response with status, entry
// count and an empty flag. A transaction runs as a compare step and a shift
// step: as the request is accepted all cells compare the byte in parallel
// and latch where it falls, then the cells shift one place toward or away
// from that point. The next request is taken in the cycle after the shift,
// so the block takes no new request before the last one has shifted; a
// stalled response holds the shift until its register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_byte_list_defines.svh"

module sorted_byte_list (
  input wire logic clk,
  input wire logic rst,
  sbl_req_if.sink  req,
  sbl_rsp_if.source rsp
);
  import sbl_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [DATA_W-1:0] key;
  kind_t             kind;
  cell_ctl_t         ctl;
  logic [DATA_W-1:0] key_bus;
  logic              xfer;
  logic              commit;
  logic              found;
  logic              full;
  logic              ins_ok;
  logic              del_ok;
  status_t           status_next;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] ge_now;
  logic [CAPACITY-1:0] hit;

  assign req.ready = (state == S_IDLE);
  assign xfer      = req.valid && req.ready;
  assign key_bus   = (state == S_IDLE) ? req.value : key;
  assign found     = |hit;
  assign full      = (count == CNT_W'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic              l_ge_now;
    logic              l_ge;
    logic [DATA_W-1:0] l_data;
    logic [DATA_W-1:0] r_data;

    assign occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign l_ge_now = 1'b0;
      assign l_ge     = 1'b0;
      assign l_data   = '0;
    end else begin : g_mid
      assign l_ge_now = ge_now[i-1];
      assign l_ge     = ge[i-1];
      assign l_data   = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_data = '0;
    end else begin : g_inner
      assign r_data = cell_data[i+1];
    end

    sbl_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .key         (key_bus),
      .occ         (occ[i]),
      .left_ge_now (l_ge_now),
      .left_ge     (l_ge),
      .left_data   (l_data),
      .right_data  (r_data),
      .data        (cell_data[i]),
      .ge          (ge[i]),
      .ge_now      (ge_now[i]),
      .hit         (hit[i])
    );
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    commit      = 1'b0;
    ins_ok      = 1'b0;
    del_ok      = 1'b0;
    status_next = ST_MISSING;
    ctl         = '0;
    case (state)
      S_IDLE: begin
        ctl.cmp = xfer;
        if (xfer) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // Hold the shift while an untaken response sits in the register.
        commit = !rsp.valid || rsp.ready;
        ins_ok = (kind == KIND_INSERT) && !full;
        del_ok = (kind == KIND_DELETE) && found;
        if (kind == KIND_INSERT) begin
          status_next = full ? ST_FULL : ST_INSERTED;
        end else begin
          status_next = found ? ST_REMOVED : ST_MISSING;
        end
        if (commit) begin
          ctl.ins    = ins_ok;
          ctl.del    = del_ok;
          state_next = S_IDLE;
          if (ins_ok) begin
            count_next = count + CNT_W'(1);
          end else if (del_ok) begin
            count_next = count - CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (commit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      key  <= req.value;
      kind <= req.kind;
    end
    if (commit) begin
      rsp.status      <= status_next;
      rsp.entry_count <= COUNT_OUT_W'(count_next);
      rsp.list_empty  <= (count_next == '0);
    end
  end

  `SBL_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(CAPACITY))
  `SBL_ASSERT(a_single_hit, clk, rst, (state == S_EXEC) |-> $onehot0(hit))
  `SBL_ASSERT(a_accept_to_exec, clk, rst, xfer |=> (state == S_EXEC))
  `SBL_ASSERT(a_insert_grows, clk, rst, (commit && ins_ok) |=> (count == $past(count) + CNT_W'(1)))
  `SBL_ASSERT(a_empty_flag, clk, rst, rsp.valid |-> (rsp.list_empty == (count == '0)))

endmodule

`default_nettype wire

// ===== hw/rtl/sbl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbl_cell (
  input  wire logic                      clk,
  input  wire sbl_pkg::cell_ctl_t        ctl,
  input  wire logic [sbl_pkg::DATA_W-1:0] key,
  input  wire logic                      occ,
  input  wire logic                      left_ge_now,
  input  wire logic                      left_ge,
  input  wire logic [sbl_pkg::DATA_W-1:0] left_data,
  input  wire logic [sbl_pkg::DATA_W-1:0] right_data,
  output logic      [sbl_pkg::DATA_W-1:0] data,
  output logic                           ge,
  output logic                           ge_now,
  output logic                           hit
);
  import sbl_pkg::*;

  // At or past the insert point: empty slot or an entry not below the key.
  assign ge_now = !(occ && (data < key));

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      ge  <= ge_now;
      hit <= occ && (data == key) && !left_ge_now;
    end
    if (ctl.ins) begin
      if (left_ge) begin
        data <= left_data;
      end else if (ge) begin
        data <= key;
      end
    end else if (ctl.del) begin
      if (ge) begin
        data <= right_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_sorted_byte_list.sv =====
`timescale 1ns / 1ps

module tb_sorted_byte_list;
  import sbl_pkg::*;

  localparam int RANDOM_ITEMS = 726;
  localparam int HOLD_START   = 600;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    status_t                status;
    logic [COUNT_OUT_W-1:0] count;
    logic                   empty;
  } outcome_t;

  typedef struct packed {
    kind_t             kind;
    logic [DATA_W-1:0] value;
    logic              fixed;
    outcome_t          outcome;
  } step_t;

  localparam outcome_t NO_OUTCOME = '{ST_INSERTED, 5'd0, 1'b0};

  logic clk = 1'b0;
  logic rst;

  sbl_req_if req_ch ();
  sbl_rsp_if rsp_ch ();

  sorted_byte_list i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the list, updated at every accepted request.
  logic [DATA_W-1:0] shadow_list [CAPACITY];
  int                shadow_count;
  outcome_t          outcome_q [$];

  // Travels with the offered request: a hand-typed outcome overrides the shadow one.
  logic     offer_fixed;
  outcome_t offer_outcome;

  int err_count;
  int burst_left;

  // Directed sequence: empty list, zero and 255, duplicates, fill to the top,
  // refused insert, absent delete, duplicate removal.
  step_t steps [24] = '{
    '{KIND_DELETE, 8'd0,   1'b1, '{ST_MISSING,  5'd0,  1'b1}},
    '{KIND_DELETE, 8'd255, 1'b1, '{ST_MISSING,  5'd0,  1'b1}},
    '{KIND_INSERT, 8'd0,   1'b1, '{ST_INSERTED, 5'd1,  1'b0}},
    '{KIND_DELETE, 8'd0,   1'b1, '{ST_REMOVED,  5'd0,  1'b1}},
    '{KIND_INSERT, 8'd255, 1'b1, '{ST_INSERTED, 5'd1,  1'b0}},
    '{KIND_INSERT, 8'd255, 1'b0, NO_OUTCOME},
    '{KIND_INSERT, 8'd0,   1'b0, NO_OUTCOME},
    '{KIND_INSERT, 8'd128, 1'b0, NO_OUTCOME},
    '{KIND_INSERT, 8'd127, 1'b0, NO_OUTCOME},
    '{KIND_INSERT, 8'd1,   1'b0, NO_OUTCOME},
    '{KIND_INSERT, 8'd254, 1'b0, NO_OUTCOME},
    '{KIND_INSERT, 8'd85,  1'b0, NO_OUTCOME},
    '{KIND_INSERT, 8'd170, 1'b0, NO_OUTCOME},
    '{KIND_INSERT, 8'd128, 1'b0, NO_OUTCOME},
    '{KIND_INSERT, 8'd0,   1'b0, NO_OUTCOME},
    '{KIND_INSERT, 8'd64,  1'b0, NO_OUTCOME},
    '{KIND_INSERT, 8'd200, 1'b0, NO_OUTCOME},
    '{KIND_INSERT, 8'd2,   1'b0, NO_OUTCOME},
    '{KIND_INSERT, 8'd253, 1'b0, NO_OUTCOME},
    '{KIND_INSERT, 8'd100, 1'b0, NO_OUTCOME},
    '{KIND_INSERT, 8'd9,   1'b1, '{ST_FULL,     5'd16, 1'b0}},
    '{KIND_DELETE, 8'd51,  1'b1, '{ST_MISSING,  5'd16, 1'b0}},
    '{KIND_DELETE, 8'd255, 1'b0, NO_OUTCOME},
    '{KIND_DELETE, 8'd0,   1'b0, NO_OUTCOME}
  };

  function automatic outcome_t apply_to_shadow(kind_t kind, logic [DATA_W-1:0] value);
    outcome_t res;
    int       pos;
    pos = 0;
    if (kind == KIND_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        while (pos < shadow_count && value > shadow_list[pos]) pos++;
        for (int i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[pos] = value;
        shadow_count++;
        res.status = ST_INSERTED;
      end
    end else begin
      while (pos < shadow_count && shadow_list[pos] != value) pos++;
      if (pos >= shadow_count) begin
        res.status = ST_MISSING;
      end else begin
        for (int i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
        shadow_count--;
        res.status = ST_REMOVED;
      end
    end
    res.count = COUNT_OUT_W'(shadow_count);
    res.empty = (shadow_count == 0);
    return res;
  endfunction

  task automatic report(input string what, input int got, input int want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Requests are predicted before responses are checked, so one edge may carry both.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        want = apply_to_shadow(req_ch.kind, req_ch.value);
        outcome_q.push_back(offer_fixed ? offer_outcome : want);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (outcome_q.size() == 0) begin
          report("unsolicited response status", rsp_ch.status, -1);
        end else begin
          want = outcome_q.pop_front();
          if (rsp_ch.status !== want.status)
            report("status", rsp_ch.status, want.status);
          if (rsp_ch.entry_count !== want.count)
            report("entry_count", rsp_ch.entry_count, want.count);
          if (rsp_ch.list_empty !== want.empty)
            report("list_empty", rsp_ch.list_empty, want.empty);
        end
      end
    end
  end

  task automatic offer(input kind_t kind, input logic [DATA_W-1:0] value,
                       input logic fixed, input outcome_t outcome);
    req_ch.valid  <= 1'b1;
    req_ch.kind   <= kind;
    req_ch.value  <= value;
    offer_fixed   <= fixed;
    offer_outcome <= outcome;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // End a burst with a random gap, then pick the next burst length.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
  endtask

  // Deletes mostly hit stored entries; a small pool of values breeds duplicates.
  task automatic pick_request(input int insert_pct, output kind_t kind,
                              output logic [DATA_W-1:0] value);
    int sel;
    kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_DELETE;
    sel  = $urandom_range(0, 9);
    if (kind == KIND_DELETE && shadow_count > 0 && sel < 7)
      value = shadow_list[$urandom_range(0, shadow_count - 1)];
    else if (sel < 4)
      value = DATA_W'($urandom_range(0, 255));
    else case ($urandom_range(0, 5))
      0: value = 8'd0;
      1: value = 8'd255;
      2: value = 8'd127;
      3: value = 8'd128;
      default: value = DATA_W'($urandom_range(10, 13));
    endcase
  endtask

  initial begin
    kind_t             kind;
    logic [DATA_W-1:0] value;
    int                left;
    int                seg_len;
    int                insert_pct;
    err_count     = 0;
    shadow_count  = 0;
    burst_left    = 0;
    rst           = 1'b1;
    req_ch.valid  <= 1'b0;
    req_ch.kind   <= KIND_INSERT;
    req_ch.value  <= '0;
    offer_fixed   <= 1'b0;
    offer_outcome <= NO_OUTCOME;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[i]) begin
      offer(steps[i].kind, steps[i].value, steps[i].fixed, steps[i].outcome);
      pace();
    end

    // Segments with randomly chosen insert mixes drive the list toward full or empty.
    left = RANDOM_ITEMS;
    while (left > 0) begin
      seg_len = $urandom_range(30, 120);
      case ($urandom_range(0, 3))
        0: insert_pct = 20;
        1: insert_pct = 50;
        2: insert_pct = 80;
        default: insert_pct = 95;
      endcase
      for (int n = 0; n < seg_len && left > 0; n++) begin
        pick_request(insert_pct, kind, value);
        offer(kind, value, 1'b0, NO_OUTCOME);
        left--;
        pace();
      end
    end
    req_ch.valid <= 1'b0;

    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("tb_sorted_byte_list: PASS");
    else
      $display("tb_sorted_byte_list: FAIL");
    $finish;
  end

  // Receiver: random stall modes, plus one long hold-off to back up the input.
  initial begin
    int cyc;
    int mode;
    int mode_left;
    cyc       = 0;
    mode      = 0;
    mode_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        cyc++;
        if (cyc == HOLD_START) begin
          rsp_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= (cyc % 3 != 0);
        endcase
      end
    end
  end

  initial begin
    #3_000_000;
    $display("tb_sorted_byte_list: FAIL");
    $finish;
  end

endmodule
